FILE: design/spblit_pkg.sv
// Shared types and codes for the sprite blitter with clipping and colour key.
`timescale 1ns / 1ps

package spblit_pkg;

  // Kind of an input item, carried on the slave tuser.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_READ  = 2'd2,
    ACT_BGWR  = 2'd3
  } action_e;

  // Result status.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECT    = 2'd1,
    ST_NO_SPRITE = 2'd2
  } status_e;

  // Draw modes; the fourth code draws as plain copy.
  localparam logic [1:0] MODE_COPY    = 2'd0;
  localparam logic [1:0] MODE_RESTORE = 2'd1;
  localparam logic [1:0] MODE_KEYED   = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic CFG_TKEY = 1'b0;
  localparam logic CFG_RKEY = 1'b1;
  localparam logic [7:0] TKEY_RESET = 8'h1C;
  localparam logic [7:0] RKEY_RESET = 8'h10;

  // Per-item sprite information from the tracker.
  typedef struct packed {
    logic              place;
    logic signed [10:0] col;
    logic signed [10:0] row;
    logic [1:0]        mode;
    status_e           status;
    logic              done;
  } item_t;

  // Frame write control from the placement logic.
  typedef struct packed {
    logic we;
    logic use_bg;
  } wr_ctl_t;

endpackage

FILE: design/clipped_sprite_blit_color_key.sv
// Top level of the sprite blitter with clipping and colour key.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser action, tdata sprite/pixel/address
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata read_pixel, status, sprite_done
//  cfg      in   cfg_we_i (no back-pressure)    cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while the output takes results.
// The restore path sets the stage split: background read as an item leaves the first
// stage, frame write as it leaves the second, with forwarding of that write to a
// frame read behind it.
// Reset clears sprite state and the pipeline; both stores are left as they are.
// A stalled output holds the pipeline; input stays ready while a stage is free.
`timescale 1ns / 1ps

module clipped_sprite_blit_color_key #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: sprite_x[9:0], sprite_y[19:10], sprite_width[27:20],
  //        sprite_height[35:28], draw_mode[37:36], pixel_value[45:38],
  //        frame_address[60:46], zero pad[63:61]
  input  logic [63:0] s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: read_pixel[7:0], status[9:8], sprite_done[10], zero pad[15:11]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int StoreDepth = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW      = $clog2(StoreDepth);

  logic [7:0] tkey_q, rkey_q;

  logic                s_acc;
  spblit_pkg::action_e in_act;
  spblit_pkg::item_t   trk_item;

  // First stage
  logic                s1_v_q;
  spblit_pkg::action_e s1_act_q;
  spblit_pkg::item_t   s1_item_q;
  logic [7:0]          s1_pix_q;
  logic [14:0]         s1_faddr_q;
  logic                s1_move;
  logic                s1_in_rng;
  logic [AddrW-1:0]    s1_faddr_a;
  spblit_pkg::wr_ctl_t pl_ctl;
  logic [AddrW-1:0]    pl_addr;

  // Second stage
  logic                s2_v_q;
  spblit_pkg::wr_ctl_t s2_ctl_q;
  logic [AddrW-1:0]    s2_addr_q;
  logic [7:0]          s2_pix_q;
  spblit_pkg::status_e s2_status_q;
  logic                s2_done_q;
  logic                s2_rd_q;
  logic                s2_byp_q;
  logic [7:0]          s2_byp_data_q;
  logic                s2_rdy, s2_move;

  // Output register
  logic                out_v_q;
  logic [7:0]          out_pix_q;
  spblit_pkg::status_e out_status_q;
  logic                out_done_q;
  logic                out_rdy;

  logic [7:0] fr_rdata, bg_rdata, fr_wdata;
  logic       fr_we, bg_we, byp_hit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tkey_q <= spblit_pkg::TKEY_RESET;
      rkey_q <= spblit_pkg::RKEY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spblit_pkg::CFG_TKEY: tkey_q <= cfg_wdata_i;
        spblit_pkg::CFG_RKEY: rkey_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Stage flow control
  assign out_rdy       = !out_v_q || m_axis_tready;
  assign s2_move       = s2_v_q && out_rdy;
  assign s2_rdy        = !s2_v_q || out_rdy;
  assign s1_move       = s1_v_q && s2_rdy;
  assign s_axis_tready = !s1_v_q || s2_rdy;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_act        = spblit_pkg::action_e'(s_axis_tuser);

  spblit_track #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (s_acc),
    .action_i(in_act),
    .x_i     ($signed(s_axis_tdata[9:0])),
    .y_i     ($signed(s_axis_tdata[19:10])),
    .w_i     (s_axis_tdata[27:20]),
    .h_i     (s_axis_tdata[35:28]),
    .mode_i  (s_axis_tdata[37:36]),
    .item_o  (trk_item)
  );

  // Capture an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_act_q   <= in_act;
      s1_item_q  <= trk_item;
      s1_pix_q   <= s_axis_tdata[45:38];
      s1_faddr_q <= s_axis_tdata[60:46];
    end
  end

  spblit_place #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_place (
    .item_i(s1_item_q),
    .pix_i (s1_pix_q),
    .tkey_i(tkey_q),
    .rkey_i(rkey_q),
    .ctl_o (pl_ctl),
    .addr_o(pl_addr)
  );

  assign s1_in_rng  = 32'(s1_faddr_q) < 32'(StoreDepth);
  assign s1_faddr_a = AddrW'(s1_faddr_q);
  assign bg_we      = s1_move && (s1_act_q == spblit_pkg::ACT_BGWR) && s1_in_rng;

  // Frame write leaves the second stage; pass it on to a read of the same entry
  assign fr_we    = s2_move && s2_ctl_q.we;
  assign fr_wdata = s2_ctl_q.use_bg ? bg_rdata : s2_pix_q;
  assign byp_hit  = fr_we && (s1_act_q == spblit_pkg::ACT_READ) && s1_in_rng &&
                    (s2_addr_q == s1_faddr_a);

  spblit_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_bg_ram (
    .clk_i  (clk_i),
    .we_i   (bg_we),
    .waddr_i(s1_faddr_a),
    .wdata_i(s1_pix_q),
    .re_i   (s1_move),
    .raddr_i(pl_addr),
    .rdata_o(bg_rdata)
  );

  spblit_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (fr_we),
    .waddr_i(s2_addr_q),
    .wdata_i(fr_wdata),
    .re_i   (s1_move),
    .raddr_i(s1_faddr_a),
    .rdata_o(fr_rdata)
  );

  // Advance into the second stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_ctl_q      <= pl_ctl;
      s2_addr_q     <= pl_addr;
      s2_pix_q      <= s1_pix_q;
      s2_status_q   <= s1_item_q.status;
      s2_done_q     <= s1_item_q.done;
      s2_rd_q       <= (s1_act_q == spblit_pkg::ACT_READ) && s1_in_rng;
      s2_byp_q      <= byp_hit;
      s2_byp_data_q <= fr_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_pix_q    <= s2_rd_q ? (s2_byp_q ? s2_byp_data_q : fr_rdata) : 8'd0;
      out_status_q <= s2_status_q;
      out_done_q   <= s2_done_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b00000, out_done_q, out_status_q, out_pix_q};

  // Second stage holds its item while the output stalls
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !out_rdy |=> s2_v_q && $stable(s2_addr_q))
    else $error("second stage changed under an output stall");

  // No item is taken into a full first stage that cannot drain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> !s1_v_q || s1_move)
    else $error("item accepted over a held first stage");

  // Forwarding only serves frame reads
  a_byp_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && s2_byp_q |-> s2_rd_q)
    else $error("forwarded frame data on a non-read item");

  // Frame and background writes only come from valid stages
  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_we |-> s2_v_q) and (bg_we |-> s1_v_q))
    else $error("store write without a valid item");

endmodule

FILE: design/spblit_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spblit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20480
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/spblit_track.sv
// Sprite tracker: start latch, rejection test, pixel counters and status.
`timescale 1ns / 1ps

module spblit_track #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 160
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  spblit_pkg::action_e action_i,
  input  logic signed [9:0]   x_i,
  input  logic signed [9:0]   y_i,
  input  logic [7:0]          w_i,
  input  logic [7:0]          h_i,
  input  logic [1:0]          mode_i,
  output spblit_pkg::item_t   item_o
);

  localparam logic signed [11:0] WidthS  = 12'(SCREEN_WIDTH);
  localparam logic signed [11:0] HeightS = 12'(SCREEN_HEIGHT);
  localparam logic [8:0]         WidthU  = 9'(SCREEN_WIDTH);
  localparam logic [8:0]         HeightU = 9'(SCREEN_HEIGHT);

  logic signed [9:0] origin_col_q, origin_col_d;
  logic signed [9:0] origin_row_q, origin_row_d;
  logic [7:0]        width_q, width_d;
  logic [7:0]        height_q, height_d;
  logic [1:0]        mode_q, mode_d;
  logic [7:0]        col_q, col_d;
  logic [7:0]        row_q, row_d;
  logic              pending_q, pending_d;
  logic              rejected_q, rejected_d;

  logic signed [11:0] x12, y12, w12, h12;
  logic               reject;
  logic               col_last, row_last;

  // Rejection test on the start fields
  always_comb begin
    x12 = 12'(x_i);
    y12 = 12'(y_i);
    w12 = $signed({4'b0000, w_i});
    h12 = $signed({4'b0000, h_i});
    reject = (x12 >= WidthS) || (y12 - h12 + 12'sd1 >= HeightS) ||
             (x12 + w12 <= 12'sd0) || (y12 < 12'sd0) ||
             ({1'b0, w_i} > WidthU) || ({1'b0, h_i} > HeightU) ||
             (w_i == 8'd0) || (h_i == 8'd0);
  end

  assign col_last = ({1'b0, col_q} + 9'd1) >= {1'b0, width_q};
  assign row_last = ({1'b0, row_q} + 9'd1) >= {1'b0, height_q};

  // Per-item answer from the current sprite state
  always_comb begin
    item_o.col   = {origin_col_q[9], origin_col_q} + $signed({3'b000, col_q});
    item_o.row   = {origin_row_q[9], origin_row_q} - $signed({3'b000, row_q});
    item_o.mode  = mode_q;
    item_o.place = (action_i == spblit_pkg::ACT_PIXEL) && pending_q && !rejected_q;
    item_o.done  = (action_i == spblit_pkg::ACT_PIXEL) && pending_q && col_last && row_last;
    case (action_i)
      spblit_pkg::ACT_START: begin
        item_o.status = reject ? spblit_pkg::ST_REJECT : spblit_pkg::ST_OK;
      end
      spblit_pkg::ACT_PIXEL: begin
        if (!pending_q) begin
          item_o.status = spblit_pkg::ST_NO_SPRITE;
        end else if (rejected_q) begin
          item_o.status = spblit_pkg::ST_REJECT;
        end else begin
          item_o.status = spblit_pkg::ST_OK;
        end
      end
      default: begin
        item_o.status = spblit_pkg::ST_OK;
      end
    endcase
  end

  // Latch a start, advance the counters on a pending pixel
  always_comb begin
    origin_col_d = origin_col_q;
    origin_row_d = origin_row_q;
    width_d      = width_q;
    height_d     = height_q;
    mode_d       = mode_q;
    col_d        = col_q;
    row_d        = row_q;
    pending_d    = pending_q;
    rejected_d   = rejected_q;
    if (acc_i) begin
      case (action_i)
        spblit_pkg::ACT_START: begin
          origin_col_d = x_i;
          origin_row_d = y_i;
          width_d      = w_i;
          height_d     = h_i;
          mode_d       = mode_i;
          col_d        = 8'd0;
          row_d        = 8'd0;
          rejected_d   = reject;
          pending_d    = (w_i != 8'd0) && (h_i != 8'd0);
        end
        spblit_pkg::ACT_PIXEL: begin
          if (pending_q) begin
            if (col_last) begin
              col_d = 8'd0;
              if (row_last) begin
                row_d     = 8'd0;
                pending_d = 1'b0;
              end else begin
                row_d = row_q + 8'd1;
              end
            end else begin
              col_d = col_q + 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q <= '0;
      origin_row_q <= '0;
      width_q      <= '0;
      height_q     <= '0;
      mode_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      pending_q    <= 1'b0;
      rejected_q   <= 1'b0;
    end else begin
      origin_col_q <= origin_col_d;
      origin_row_q <= origin_row_d;
      width_q      <= width_d;
      height_q     <= height_d;
      mode_q       <= mode_d;
      col_q        <= col_d;
      row_q        <= row_d;
      pending_q    <= pending_d;
      rejected_q   <= rejected_d;
    end
  end

  // Counters stay inside the held sprite
  a_col_in_sprite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (col_q < width_q) && (row_q < height_q))
    else $error("pixel counter beyond held sprite size");

endmodule

FILE: design/spblit_place.sv
// Pixel placement: clip to screen, store address and colour key decision.
`timescale 1ns / 1ps

module spblit_place #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 160
) (
  input  spblit_pkg::item_t                         item_i,
  input  logic [7:0]                                pix_i,
  input  logic [7:0]                                tkey_i,
  input  logic [7:0]                                rkey_i,
  output spblit_pkg::wr_ctl_t                       ctl_o,
  output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] addr_o
);

  localparam int AddrW = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam int RowW  = $clog2(SCREEN_HEIGHT);
  localparam logic [AddrW-1:0] WidthA  = AddrW'(SCREEN_WIDTH);
  localparam logic [RowW-1:0]  TopRow  = RowW'(SCREEN_HEIGHT - 1);

  logic             on_screen;
  logic             keep;
  logic [RowW-1:0]  flip_row;

  // Clip to the screen
  assign on_screen = !item_i.col[10] && (item_i.col[9:0] < 10'(SCREEN_WIDTH)) &&
                     !item_i.row[10] && (item_i.row[9:0] < 10'(SCREEN_HEIGHT));

  // Store rows run from the top of the screen down
  assign flip_row = TopRow - item_i.row[RowW-1:0];
  assign addr_o   = AddrW'(flip_row) * WidthA + AddrW'(item_i.col[9:0]);

  // Colour key: in restore mode, restore wins over transparent when both keys match
  always_comb begin
    keep          = 1'b0;
    ctl_o.use_bg  = 1'b0;
    case (item_i.mode)
      spblit_pkg::MODE_RESTORE: begin
        ctl_o.use_bg = (pix_i == rkey_i);
        keep         = (pix_i != rkey_i) && (pix_i == tkey_i);
      end
      spblit_pkg::MODE_KEYED: begin
        keep = (pix_i == tkey_i);
      end
      default: begin
      end
    endcase
    ctl_o.we = item_i.place && on_screen && !keep;
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the clipped sprite blitter with colour key.
`timescale 1ns / 1ps

module tb_top;

  localparam int SCREEN_W     = 128;
  localparam int SCREEN_H     = 160;
  localparam int STORE_DEPTH  = SCREEN_W * SCREEN_H;
  localparam int ADDR_SPAN    = 32768;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  // The fourth draw mode code has no name in the package; it draws as plain copy.
  localparam logic [1:0] MODE_ALIAS_COPY = 2'd3;

  // One input item, fields as carried on the slave bus
  typedef struct packed {
    spblit_pkg::action_e act;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [1:0]  mode;
    logic [7:0]  pix;
    logic [14:0] addr;
  } blit_item_t;

  // One result item
  typedef struct packed {
    logic [7:0]          rd;
    spblit_pkg::status_e st;
    logic                done;
  } blit_result_t;

  // Frame and background stores, sprite tracker and the queue of awaited results
  class sprite_frame_scoreboard;
    bit [7:0] frame_mem [STORE_DEPTH];
    bit [7:0] bg_mem [STORE_DEPTH];
    bit       frame_set [STORE_DEPTH];
    bit       bg_set [STORE_DEPTH];
    int       painted [$];
    int       last_painted;
    int       org_col, org_row, held_w, held_h, col_cnt, row_cnt;
    logic [1:0] held_mode;
    bit       pending, rejected;
    logic [7:0] tkey, rkey;
    blit_result_t awaited [$];
    int       mismatches, items_seen, results_seen, sprites_done, restores, reads;

    function new();
      tkey = spblit_pkg::TKEY_RESET;
      rkey = spblit_pkg::RKEY_RESET;
      last_painted = -1;
      held_mode = spblit_pkg::MODE_COPY;
    endfunction

    function void set_key(logic idx, logic [7:0] v);
      if (idx == spblit_pkg::CFG_TKEY) tkey = v;
      else rkey = v;
    endfunction

    // Store address of sprite pixel (col,row), or -1 when clipped
    function int screen_addr(int col, int row);
      int c, r;
      c = org_col + col;
      r = org_row - row;
      if (c < 0 || c >= SCREEN_W || r < 0 || r >= SCREEN_H) return -1;
      return (SCREEN_H - 1 - r) * SCREEN_W + c;
    endfunction

    // True when this pixel value would restore from a background entry never loaded
    function bit restore_hazard(logic [7:0] v);
      int a;
      if (!pending || rejected || held_mode != spblit_pkg::MODE_RESTORE || v != rkey)
        return 1'b0;
      a = screen_addr(col_cnt, row_cnt);
      return (a >= 0) && !bg_set[a];
    endfunction

    function void paint(int a, logic [7:0] v);
      frame_mem[a] = v;
      if (!frame_set[a]) begin
        frame_set[a] = 1'b1;
        painted.push_back(a);
      end
      last_painted = a;
    endfunction

    function void absorb_item(blit_item_t it);
      blit_result_t res;
      int a;
      res.rd = 8'h00;
      res.st = spblit_pkg::ST_OK;
      res.done = 1'b0;
      items_seen++;
      case (it.act)
        spblit_pkg::ACT_START: begin
          org_col = $signed(it.x);
          org_row = $signed(it.y);
          held_w = it.w;
          held_h = it.h;
          held_mode = it.mode;
          col_cnt = 0;
          row_cnt = 0;
          rejected = (org_col >= SCREEN_W) || (org_row - held_h + 1 >= SCREEN_H) ||
                     (org_col + held_w <= 0) || (org_row < 0) ||
                     (held_w > SCREEN_W) || (held_h > SCREEN_H) ||
                     (held_w == 0) || (held_h == 0);
          pending = (held_w != 0) && (held_h != 0);
          if (rejected) res.st = spblit_pkg::ST_REJECT;
        end
        spblit_pkg::ACT_PIXEL: begin
          if (!pending) begin
            res.st = spblit_pkg::ST_NO_SPRITE;
          end else begin
            if (rejected) begin
              res.st = spblit_pkg::ST_REJECT;
            end else begin
              a = screen_addr(col_cnt, row_cnt);
              // Restore key wins over the transparent key in restore mode
              if (a >= 0) begin
                if (held_mode == spblit_pkg::MODE_RESTORE && it.pix == rkey) begin
                  paint(a, bg_mem[a]);
                  restores++;
                end else if (!((held_mode == spblit_pkg::MODE_RESTORE ||
                                held_mode == spblit_pkg::MODE_KEYED) &&
                               it.pix == tkey)) begin
                  paint(a, it.pix);
                end
              end
            end
            // Advance left to right, then down a row
            if (col_cnt + 1 >= held_w) begin
              col_cnt = 0;
              if (row_cnt + 1 >= held_h) begin
                row_cnt = 0;
                pending = 1'b0;
                res.done = 1'b1;
                sprites_done++;
              end else begin
                row_cnt++;
              end
            end else begin
              col_cnt++;
            end
          end
        end
        spblit_pkg::ACT_READ: begin
          reads++;
          if (it.addr < STORE_DEPTH) res.rd = frame_mem[it.addr];
        end
        default: begin
          if (it.addr < STORE_DEPTH) begin
            bg_mem[it.addr] = it.pix;
            bg_set[it.addr] = 1'b1;
          end
        end
      endcase
      awaited.push_back(res);
    endfunction

    function void check_result(logic [15:0] data);
      blit_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %04h with none awaited", data);
        return;
      end
      want = awaited.pop_front();
      if (data[7:0] !== want.rd || data[9:8] !== want.st || data[10] !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Result %0d mismatch: expected pixel %02h status %0d done %0d,",
                    " got pixel %02h status %0d done %0d"},
                   results_seen, want.rd, want.st, want.done,
                   data[7:0], data[9:8], data[10]);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // tdata: sprite_x, sprite_y, sprite_width, sprite_height, draw_mode, pixel_value,
  //        frame_address, zero pad
  logic [63:0] s_axis_tdata = '0;
  // tuser: action
  logic [1:0]  s_axis_tuser = spblit_pkg::ACT_READ;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: read_pixel, status, sprite_done, zero pad
  logic [15:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = spblit_pkg::CFG_TKEY;
  logic [7:0]  cfg_wdata_i = '0;

  sprite_frame_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit long_hold_armed = 1'b0;

  clipped_sprite_blit_color_key #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [63:0] pack_bus(blit_item_t it);
    return {3'b000, it.addr, it.pix, it.mode, it.h, it.w, it.y, it.x};
  endfunction

  function automatic blit_item_t unpack_bus(logic [63:0] d, logic [1:0] u);
    blit_item_t it;
    it.act  = spblit_pkg::action_e'(u);
    it.x    = d[9:0];
    it.y    = d[19:10];
    it.w    = d[27:20];
    it.h    = d[35:28];
    it.mode = d[37:36];
    it.pix  = d[45:38];
    it.addr = d[60:46];
    return it;
  endfunction

  // Sample both handshakes at the falling edge before the rising edge that completes them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.absorb_item(unpack_bus(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_armed) begin
        long_hold_armed = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no handshake for %0d cycles, %0d results still awaited",
             QUIET_LIMIT, sb.outstanding());
    $display("Regression FAIL");
    $finish;
  end

  function automatic blit_item_t random_fill();
    blit_item_t it;
    it.act  = spblit_pkg::action_e'($urandom_range(3));
    it.x    = 10'($urandom_range(1023));
    it.y    = 10'($urandom_range(1023));
    it.w    = 8'($urandom_range(255));
    it.h    = 8'($urandom_range(255));
    it.mode = 2'($urandom_range(3));
    it.pix  = 8'($urandom_range(255));
    it.addr = 15'($urandom_range(ADDR_SPAN - 1));
    return it;
  endfunction

  // Frame address that is safe to read: painted, or beyond the store
  function automatic int safe_read_addr();
    if (sb.painted.size() == 0 || $urandom_range(99) < 15)
      return $urandom_range(ADDR_SPAN - 1, STORE_DEPTH);
    if ($urandom_range(1) == 0) return sb.last_painted;
    return sb.painted[$urandom_range(sb.painted.size() - 1)];
  endfunction

  // Offer one item and hold it until taken; called and returning at a rising edge
  task automatic push_item(input blit_item_t it);
    bit ready_seen;
    if (it.act == spblit_pkg::ACT_PIXEL && sb.restore_hazard(it.pix)) it.pix ^= 8'h01;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_bus(it);
    s_axis_tuser  <= it.act;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    if (!(it.act == spblit_pkg::ACT_BGWR && it.addr >= STORE_DEPTH)) items_sent++;
  endtask

  task automatic put_start(input int x, input int y, input int w, input int h,
                           input logic [1:0] mode);
    blit_item_t it;
    it = random_fill();
    it.act  = spblit_pkg::ACT_START;
    it.x    = x[9:0];
    it.y    = y[9:0];
    it.w    = w[7:0];
    it.h    = h[7:0];
    it.mode = mode;
    push_item(it);
  endtask

  task automatic put_pixel(input logic [7:0] v);
    blit_item_t it;
    it = random_fill();
    it.act = spblit_pkg::ACT_PIXEL;
    it.pix = v;
    push_item(it);
  endtask

  task automatic put_read(input int a);
    blit_item_t it;
    it = random_fill();
    it.act  = spblit_pkg::ACT_READ;
    it.addr = a[14:0];
    push_item(it);
  endtask

  task automatic put_bg(input int a, input logic [7:0] v);
    blit_item_t it;
    it = random_fill();
    it.act  = spblit_pkg::ACT_BGWR;
    it.addr = a[14:0];
    it.pix  = v;
    push_item(it);
  endtask

  // Drop valid and wait until every awaited result is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_key(input logic idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_key(idx, v);
    @(posedge clk_i);
  endtask

  // Edge cases with the reset keys
  task automatic directed_items();
    put_pixel(8'h55);                                   // no sprite pending
    put_start(10, 10, 0, 4, spblit_pkg::MODE_COPY);     // zero width: rejected
    put_pixel(8'h00);
    put_start(10, 10, 3, 0, spblit_pkg::MODE_KEYED);    // zero height
    put_start(-512, 511, 255, 255, spblit_pkg::MODE_KEYED); // off screen and oversized
    put_pixel(8'hFF);
    put_start(511, -512, 1, 1, spblit_pkg::MODE_COPY);  // off to the right
    put_pixel(8'hAA);
    put_start(-1, 0, 2, 2, spblit_pkg::MODE_COPY);      // clipped left and below
    put_pixel(8'h11);
    put_pixel(8'h22);
    put_pixel(8'h33);
    put_pixel(8'h44);
    put_bg(127, 8'h9D);
    put_bg(ADDR_SPAN - 1, 8'hFF);                       // beyond the store: ignored
    put_start(SCREEN_W - 1, SCREEN_H - 1, 1, 1, spblit_pkg::MODE_RESTORE);
    put_pixel(spblit_pkg::RKEY_RESET);                  // restore from background
    put_start(SCREEN_W - 1, SCREEN_H - 1, 1, 1, spblit_pkg::MODE_KEYED);
    put_pixel(spblit_pkg::TKEY_RESET);                  // transparent: frame unchanged
    put_read(127);
    put_start(0, 0, 1, 1, MODE_ALIAS_COPY);
    put_pixel(spblit_pkg::TKEY_RESET);                  // fourth mode copies the key value
    put_start(5, 5, 3, 1, spblit_pkg::MODE_COPY);
    put_pixel(8'h7E);
    put_start(5, 5, 1, 1, spblit_pkg::MODE_RESTORE);    // abandons the sprite before
    put_pixel(spblit_pkg::TKEY_RESET);
    put_read((SCREEN_H - 1 - 5) * SCREEN_W + 5);
    put_read(ADDR_SPAN - 1);
  endtask

  // A start followed by its pixels, with background loads and read-backs
  task automatic run_sprite();
    int w, h, x, y, k, n;
    logic [1:0] mode;
    logic [7:0] v;
    k = $urandom_range(99);
    if (k < 2) begin
      w = SCREEN_W;
      h = $urandom_range(1, 2);
    end else if (k < 4) begin
      w = 1;
      h = SCREEN_H;
    end else if (k < 8) begin
      w = $urandom_range(SCREEN_W + 1, 255);
      h = $urandom_range(1, 255);
    end else if (k < 11) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(SCREEN_H + 1, 255);
    end else if (k < 13) begin
      w = $urandom_range(1) ? 0 : $urandom_range(1, 6);
      h = (w == 0) ? $urandom_range(0, 6) : 0;
    end else begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
    end
    // Mostly near the screen edges, sometimes anywhere
    if ($urandom_range(99) < 80) begin
      x = $urandom_range(SCREEN_W + 2 + w);
      x = x - w - 1;
      y = $urandom_range(SCREEN_H + 2 + h);
      y = y - 1;
    end else begin
      x = $urandom_range(1023);
      x = x - 512;
      y = $urandom_range(1023);
      y = y - 512;
    end
    mode = 2'($urandom_range(3));
    put_start(x, y, w, h, mode);
    // Load background under most of a small restore sprite
    if (mode == spblit_pkg::MODE_RESTORE && !sb.rejected && w * h <= 36) begin
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          if (sb.screen_addr(c, r) >= 0 && $urandom_range(99) < 70)
            put_bg(sb.screen_addr(c, r), 8'($urandom_range(255)));
    end
    n = w * h;
    if (sb.rejected && n > 8) n = $urandom_range(1, 4);
    else if (n > 1 && $urandom_range(99) < 10) n = $urandom_range(1, n - 1);
    repeat (n) begin
      k = $urandom_range(3);
      v = (k == 0) ? sb.tkey : (k == 1) ? sb.rkey : 8'($urandom_range(255));
      put_pixel(v);
    end
    repeat ($urandom_range(2)) put_read(safe_read_addr());
  endtask

  task automatic random_phase(input int count);
    int first, k;
    blit_item_t it;
    first = items_sent;
    while (items_sent - first < count) begin
      k = $urandom_range(99);
      if (k < 70) begin
        run_sprite();
      end else if (k < 80) begin
        put_bg(($urandom_range(99) < 85) ? $urandom_range(STORE_DEPTH - 1)
                                         : $urandom_range(ADDR_SPAN - 1),
               8'($urandom_range(255)));
      end else if (k < 88) begin
        put_read(safe_read_addr());
      end else begin
        // Noise: any action with random fields
        it = random_fill();
        if (it.act == spblit_pkg::ACT_READ) it.addr = 15'(safe_read_addr());
        push_item(it);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();
    wait_idle();

    write_key(spblit_pkg::CFG_TKEY, 8'h00);
    write_key(spblit_pkg::CFG_RKEY, 8'hFF);
    tx_idle_pct = 29;
    rx_idle_pct = 49;
    random_phase(140);
    wait_idle();

    write_key(spblit_pkg::CFG_TKEY, 8'hFF);
    write_key(spblit_pkg::CFG_RKEY, 8'h00);
    tx_idle_pct = 49;
    rx_idle_pct = 29;
    random_phase(140);
    wait_idle();

    // Equal keys, full rate, and one long output stall to back up the input
    write_key(spblit_pkg::CFG_TKEY, 8'h5A);
    write_key(spblit_pkg::CFG_RKEY, 8'h5A);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_armed = 1'b1;
    random_phase(140);
    wait_idle();

    $display({"Run covered %0d items and %0d results: %0d sprites finished,",
              " %0d restores, %0d frame reads"},
             sb.items_seen, sb.results_seen, sb.sprites_done, sb.restores, sb.reads);
    $display({"Four key settings incl. equal keys, edge clipping, rejected and",
              " abandoned sprites; %0d mismatches"}, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
